[design/ffca_pkg.sv]
// ---------------------------------------------------------------------------
// ffca_pkg
// shared types, constants and helpers of the first-fit chunk allocator
// ---------------------------------------------------------------------------
`default_nettype none

package ffca_pkg;

  localparam int MAX_CHUNKS = 64;
  localparam int SLOT_W     = $clog2(MAX_CHUNKS);
  localparam int PTR_W      = SLOT_W + 1;
  localparam int WALK_LIMIT = MAX_CHUNKS + 1;
  localparam int STEP_W     = $clog2(WALK_LIMIT + 1);
  localparam int COUNT_W    = $clog2(MAX_CHUNKS + 1);
  localparam int OFF_W      = 32;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [OFF_W-1:0]      off_t;
  typedef logic [MAX_CHUNKS-1:0] vld_t;

  localparam ptr_t NIL = PTR_W'(MAX_CHUNKS);
  localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(WALK_LIMIT);

  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_EXTEND = 3'd1,
    OP_FREE   = 3'd2,
    OP_FIND   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_TAIL, S_A0, S_A1, S_RELINK, S_CUTNIL, S_GROW, S_LINKT,
    S_C0, S_C1, S_C2, S_CEND, S_T0, S_T1, S_T2,
    S_F0, S_F1, S_F2, S_F3, S_F4, S_FIND, S_CLEAR, S_FIN, S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0] op;
    off_t       length;
    slot_t      first_slot;
    logic       has_first;
    off_t       offset;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    slot_t              slot;
    off_t               chunk_offset;
    off_t               chunk_length;
    slot_t              next_slot;
    logic               has_next;
    off_t               empty_space;
    logic [COUNT_W-1:0] chunk_count;
  } rsp_t;

  function automatic logic is_live(vld_t v, ptr_t p);
    return (p < NIL) && v[p[SLOT_W-1:0]];
  endfunction

  function automatic ptr_t live_or_nil(vld_t v, ptr_t p);
    return is_live(v, p) ? p : NIL;
  endfunction

  // lowest empty slot, nil when the table is full
  function automatic ptr_t first_free(vld_t v);
    ptr_t r;
    r = NIL;
    for (int i = MAX_CHUNKS - 1; i >= 0; i--) begin
      if (!v[i]) r = PTR_W'(i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/first_fit_chunk_allocator_unit.sv]
// ---------------------------------------------------------------------------
// first_fit_chunk_allocator_unit
// first-fit chunk allocator with splitting, boundary growth, chain extend,
// sorted free-list insertion, coalescing and chunk lookup by offset
// ---------------------------------------------------------------------------
//  channel | signals                      | direction | payload
//  req     | req_valid, req_ready, req    | in        | ffca_pkg::req_t
//  rsp     | rsp_valid, rsp_ready, rsp    | out       | ffca_pkg::rsp_t
//  cfg     | cfg_valid, cfg_ready, cfg_data | in      | first_length, 32 bits
//
//  one request at a time; a sequencer walks the chunk table through one read
//  port, one entry per cycle, so run time follows list lengths: find scans
//  the slots in order, alloc walks the free list, extend also walks the chain
//  to its tail plus a coalesce pass, free walks the free list per chunk freed
//  reset empties the table at once through the valid bits, no clearing pass
//  a finished result waits in the rsp register while the next request is taken
// ---------------------------------------------------------------------------
`default_nettype none

module first_fit_chunk_allocator_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire ffca_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output ffca_pkg::rsp_t      rsp,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire ffca_pkg::off_t cfg_data
);

  // chunk table
  ffca_pkg::off_t start_mem [ffca_pkg::MAX_CHUNKS];
  ffca_pkg::off_t size_mem  [ffca_pkg::MAX_CHUNKS];
  ffca_pkg::ptr_t link_mem  [ffca_pkg::MAX_CHUNKS];
  ffca_pkg::off_t rd_start, rd_size;
  ffca_pkg::ptr_t rd_link;

  ffca_pkg::slot_t rd_addr, wa_start, wa_size, wa_link;
  logic            we_start, we_size, we_link;
  ffca_pkg::off_t  wd_start, wd_size;
  ffca_pkg::ptr_t  wd_link;

  ffca_pkg::state_t state, state_next;
  ffca_pkg::vld_t   vld;
  ffca_pkg::ptr_t   free_head;
  ffca_pkg::off_t   boundary, first_length;
  logic [ffca_pkg::COUNT_W-1:0] used_count;

  logic [2:0]      mode;
  ffca_pkg::off_t  len_r, off_r;
  ffca_pkg::slot_t first_r;
  logic            has_r;

  ffca_pkg::ptr_t  acur, aprev, anx, tslot, cp, cn, fc, fnx, fprev, e;
  ffca_pkg::slot_t got, scan;
  logic [ffca_pkg::STEP_W-1:0] steps, s2;
  ffca_pkg::off_t  p_start, p_size, c_start;

  logic [1:0]      res_status;
  ffca_pkg::slot_t res_slot, res_nslot;
  ffca_pkg::off_t  res_coff, res_clen;
  logic            res_hnext;

  ffca_pkg::ptr_t rd_nx, head_live, ns, cfrom, c2_nxn;
  logic [ffca_pkg::STEP_W-1:0] steps_inc;
  logic [ffca_pkg::OFF_W:0] grow_sum, pend_sum;
  logic a_fit, a_exact, a_go, ns_ok, grow_ok, tail_go, merge, c2_go, fold;
  logic f0_go, f1_walk, f2_adv, f2_go, t1_adv, find_hit, find_last, out_free;
  logic ext_chain, req_bad, req_ext;

  assign cfg_ready = 1'b1;

  assign rd_nx     = ffca_pkg::live_or_nil(vld, rd_link);
  assign head_live = ffca_pkg::live_or_nil(vld, free_head);
  assign ns        = ffca_pkg::first_free(vld);
  assign ns_ok     = (ns != ffca_pkg::NIL);
  assign steps_inc = steps + 1'b1;
  assign cfrom     = (mode == ffca_pkg::OP_FREE) ? free_head : tslot;

  assign a_fit   = (rd_size >= len_r);
  assign a_exact = (rd_size == len_r);
  assign a_go    = (rd_nx != ffca_pkg::NIL) && (steps_inc < ffca_pkg::STEP_LIMIT);
  assign tail_go = (rd_nx != ffca_pkg::NIL) && (steps < ffca_pkg::STEP_LIMIT);
  assign grow_sum = {1'b0, boundary} + {1'b0, len_r};
  assign grow_ok  = !grow_sum[ffca_pkg::OFF_W] && ns_ok;
  assign ext_chain = (mode == ffca_pkg::OP_EXTEND) && has_r;

  assign pend_sum = {1'b0, p_start} + {1'b0, p_size};
  assign merge    = (cn != cp) && (pend_sum == {1'b0, rd_start});
  assign c2_nxn   = (merge && (rd_nx == cn)) ? ffca_pkg::NIL : rd_nx;
  assign c2_go    = (c2_nxn != ffca_pkg::NIL) && (steps_inc < ffca_pkg::STEP_LIMIT);
  assign fold     = (pend_sum == {1'b0, boundary});

  assign f0_go   = (fc != ffca_pkg::NIL) && (steps < ffca_pkg::STEP_LIMIT);
  assign f1_walk = (head_live != ffca_pkg::NIL) && (head_live != fc);
  assign f2_adv  = (rd_start < c_start) && (s2 < ffca_pkg::STEP_LIMIT);
  assign f2_go   = f2_adv && (rd_nx != ffca_pkg::NIL) && (rd_nx != fc);
  assign t1_adv  = (s2 < ffca_pkg::STEP_LIMIT);

  assign find_hit  = vld[scan] && (rd_start == off_r);
  assign find_last = (scan == ffca_pkg::SLOT_W'(ffca_pkg::MAX_CHUNKS - 1));
  assign out_free  = !rsp_valid || rsp_ready;

  assign req_ext = (req.op == ffca_pkg::OP_EXTEND);
  assign req_bad = req.has_first && !ffca_pkg::is_live(vld, {1'b0, req.first_slot});

  // table memories, write-first on a same-address read
  always_ff @(posedge clk) begin
    if (we_start) start_mem[wa_start] <= wd_start;
    if (we_size)  size_mem[wa_size]   <= wd_size;
    if (we_link)  link_mem[wa_link]   <= wd_link;
    if (we_start && wa_start == rd_addr) rd_start <= wd_start;
    else rd_start <= start_mem[rd_addr];
    if (we_size && wa_size == rd_addr) rd_size <= wd_size;
    else rd_size <= size_mem[rd_addr];
    if (we_link && wa_link == rd_addr) rd_link <= wd_link;
    else rd_link <= link_mem[rd_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ffca_pkg::S_IDLE: begin
        if (req_valid) begin
          case (ffca_pkg::op_t'(req.op))
            ffca_pkg::OP_ALLOC, ffca_pkg::OP_EXTEND: begin
              if (req_ext && req_bad) state_next = ffca_pkg::S_FIN;
              else if (req.length == '0) state_next = ffca_pkg::S_FIN;
              else if (req_ext && req.has_first) state_next = ffca_pkg::S_TAIL;
              else state_next = ffca_pkg::S_A0;
            end
            ffca_pkg::OP_FREE:  state_next = req_bad ? ffca_pkg::S_FIN : ffca_pkg::S_F0;
            ffca_pkg::OP_FIND:  state_next = ffca_pkg::S_FIND;
            ffca_pkg::OP_CLEAR: state_next = ffca_pkg::S_CLEAR;
            default:            state_next = ffca_pkg::S_FIN;
          endcase
        end
      end
      ffca_pkg::S_TAIL: if (!tail_go) state_next = ffca_pkg::S_A0;
      ffca_pkg::S_A0: begin
        state_next = (head_live == ffca_pkg::NIL) ? ffca_pkg::S_GROW : ffca_pkg::S_A1;
      end
      ffca_pkg::S_A1: begin
        if (a_fit) state_next = (a_exact || ns_ok) ? ffca_pkg::S_RELINK : ffca_pkg::S_FIN;
        else if (!a_go) state_next = ffca_pkg::S_GROW;
      end
      ffca_pkg::S_RELINK: state_next = ffca_pkg::S_CUTNIL;
      ffca_pkg::S_CUTNIL: state_next = ext_chain ? ffca_pkg::S_LINKT : ffca_pkg::S_FIN;
      ffca_pkg::S_GROW: begin
        state_next = (grow_ok && ext_chain) ? ffca_pkg::S_LINKT : ffca_pkg::S_FIN;
      end
      ffca_pkg::S_LINKT: state_next = ffca_pkg::S_C0;
      ffca_pkg::S_C0: begin
        state_next = ffca_pkg::is_live(vld, cfrom) ? ffca_pkg::S_C1 : ffca_pkg::S_FIN;
      end
      ffca_pkg::S_C1: begin
        state_next = (rd_nx == ffca_pkg::NIL) ? ffca_pkg::S_CEND : ffca_pkg::S_C2;
      end
      ffca_pkg::S_C2: if (!c2_go) state_next = ffca_pkg::S_CEND;
      ffca_pkg::S_CEND: begin
        state_next = (mode == ffca_pkg::OP_FREE && fold) ? ffca_pkg::S_T0 : ffca_pkg::S_FIN;
      end
      ffca_pkg::S_T0: begin
        if (head_live == ffca_pkg::NIL) state_next = ffca_pkg::S_FIN;
        else if (head_live == cp) state_next = ffca_pkg::S_T2;
        else state_next = ffca_pkg::S_T1;
      end
      ffca_pkg::S_T1: begin
        if (!t1_adv || rd_nx == ffca_pkg::NIL) state_next = ffca_pkg::S_FIN;
        else if (rd_nx == cp) state_next = ffca_pkg::S_T2;
      end
      ffca_pkg::S_T2: state_next = ffca_pkg::S_FIN;
      ffca_pkg::S_F0: state_next = f0_go ? ffca_pkg::S_F1 : ffca_pkg::S_C0;
      ffca_pkg::S_F1: state_next = f1_walk ? ffca_pkg::S_F2 : ffca_pkg::S_F3;
      ffca_pkg::S_F2: if (!f2_go) state_next = ffca_pkg::S_F3;
      ffca_pkg::S_F3: begin
        state_next = (e != fc && fprev != ffca_pkg::NIL) ? ffca_pkg::S_F4 : ffca_pkg::S_F0;
      end
      ffca_pkg::S_F4: state_next = ffca_pkg::S_F0;
      ffca_pkg::S_FIND: if (find_hit || find_last) state_next = ffca_pkg::S_FIN;
      ffca_pkg::S_CLEAR: state_next = ffca_pkg::S_FIN;
      ffca_pkg::S_FIN: state_next = ffca_pkg::S_DONE;
      ffca_pkg::S_DONE: if (out_free) state_next = ffca_pkg::S_IDLE;
      default: state_next = ffca_pkg::S_IDLE;
    endcase
  end

  // table port control
  always_comb begin
    req_ready = 1'b0;
    rd_addr   = '0;
    we_start  = 1'b0;
    we_size   = 1'b0;
    we_link   = 1'b0;
    wa_start  = '0;
    wa_size   = '0;
    wa_link   = '0;
    wd_start  = '0;
    wd_size   = '0;
    wd_link   = ffca_pkg::NIL;
    case (state)
      ffca_pkg::S_IDLE: begin
        req_ready = 1'b1;
        rd_addr   = (req.op == ffca_pkg::OP_FIND) ? '0 : req.first_slot;
      end
      ffca_pkg::S_TAIL: rd_addr = rd_nx[ffca_pkg::SLOT_W-1:0];
      ffca_pkg::S_A0:   rd_addr = head_live[ffca_pkg::SLOT_W-1:0];
      ffca_pkg::S_A1: begin
        rd_addr = rd_nx[ffca_pkg::SLOT_W-1:0];
        if (a_fit && !a_exact && ns_ok) begin
          we_start = 1'b1;
          we_size  = 1'b1;
          we_link  = 1'b1;
          wa_start = ns[ffca_pkg::SLOT_W-1:0];
          wa_size  = ns[ffca_pkg::SLOT_W-1:0];
          wa_link  = ns[ffca_pkg::SLOT_W-1:0];
          wd_start = rd_start + len_r;
          wd_size  = rd_size - len_r;
          wd_link  = rd_nx;
        end
      end
      ffca_pkg::S_RELINK: begin
        we_size = 1'b1;
        wa_size = acur[ffca_pkg::SLOT_W-1:0];
        wd_size = len_r;
        if (aprev != ffca_pkg::NIL) begin
          we_link = 1'b1;
          wa_link = aprev[ffca_pkg::SLOT_W-1:0];
          wd_link = anx;
        end
      end
      ffca_pkg::S_CUTNIL: begin
        we_link = 1'b1;
        wa_link = acur[ffca_pkg::SLOT_W-1:0];
        wd_link = ffca_pkg::NIL;
      end
      ffca_pkg::S_GROW: begin
        if (grow_ok) begin
          we_start = 1'b1;
          we_size  = 1'b1;
          we_link  = 1'b1;
          wa_start = ns[ffca_pkg::SLOT_W-1:0];
          wa_size  = ns[ffca_pkg::SLOT_W-1:0];
          wa_link  = ns[ffca_pkg::SLOT_W-1:0];
          wd_start = boundary;
          wd_size  = len_r;
          wd_link  = ffca_pkg::NIL;
        end
      end
      ffca_pkg::S_LINKT: begin
        we_link = 1'b1;
        wa_link = tslot[ffca_pkg::SLOT_W-1:0];
        wd_link = {1'b0, got};
      end
      ffca_pkg::S_C0: rd_addr = cfrom[ffca_pkg::SLOT_W-1:0];
      ffca_pkg::S_C1: rd_addr = rd_nx[ffca_pkg::SLOT_W-1:0];
      ffca_pkg::S_C2: begin
        rd_addr = c2_nxn[ffca_pkg::SLOT_W-1:0];
        if (merge) begin
          we_size = 1'b1;
          we_link = 1'b1;
          wa_size = cp[ffca_pkg::SLOT_W-1:0];
          wa_link = cp[ffca_pkg::SLOT_W-1:0];
          wd_size = p_size + rd_size;
          wd_link = rd_nx;
        end
      end
      ffca_pkg::S_T0: rd_addr = head_live[ffca_pkg::SLOT_W-1:0];
      ffca_pkg::S_T1: rd_addr = rd_nx[ffca_pkg::SLOT_W-1:0];
      ffca_pkg::S_T2: begin
        if (fprev != ffca_pkg::NIL) begin
          we_link = 1'b1;
          wa_link = fprev[ffca_pkg::SLOT_W-1:0];
          wd_link = ffca_pkg::NIL;
        end
      end
      ffca_pkg::S_F0: rd_addr = fc[ffca_pkg::SLOT_W-1:0];
      ffca_pkg::S_F1: rd_addr = head_live[ffca_pkg::SLOT_W-1:0];
      ffca_pkg::S_F2: rd_addr = rd_nx[ffca_pkg::SLOT_W-1:0];
      ffca_pkg::S_F3: begin
        if (e != fc) begin
          we_link = 1'b1;
          wa_link = fc[ffca_pkg::SLOT_W-1:0];
          wd_link = e;
        end
      end
      ffca_pkg::S_F4: begin
        we_link = 1'b1;
        wa_link = fprev[ffca_pkg::SLOT_W-1:0];
        wd_link = fc;
      end
      ffca_pkg::S_FIND: rd_addr = scan + 1'b1;
      ffca_pkg::S_CLEAR: begin
        if (first_length != '0) begin
          we_start = 1'b1;
          we_size  = 1'b1;
          we_link  = 1'b1;
          wd_start = '0;
          wd_size  = first_length;
          wd_link  = ffca_pkg::NIL;
        end
      end
      ffca_pkg::S_FIN, ffca_pkg::S_DONE: rd_addr = free_head[ffca_pkg::SLOT_W-1:0];
      default: rd_addr = '0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ffca_pkg::S_IDLE;
      vld          <= '0;
      free_head    <= ffca_pkg::NIL;
      boundary     <= '0;
      used_count   <= '0;
      first_length <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) first_length <= cfg_data;
      if (state == ffca_pkg::S_DONE && out_free) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      case (state)
        ffca_pkg::S_A1: begin
          if (a_fit && !a_exact && ns_ok) begin
            vld[ns[ffca_pkg::SLOT_W-1:0]] <= 1'b1;
            used_count <= used_count + 1'b1;
          end
        end
        ffca_pkg::S_RELINK: if (aprev == ffca_pkg::NIL) free_head <= anx;
        ffca_pkg::S_GROW: begin
          if (grow_ok) begin
            vld[ns[ffca_pkg::SLOT_W-1:0]] <= 1'b1;
            used_count <= used_count + 1'b1;
            boundary   <= grow_sum[ffca_pkg::OFF_W-1:0];
          end
        end
        ffca_pkg::S_C2: begin
          if (merge) begin
            vld[cn[ffca_pkg::SLOT_W-1:0]] <= 1'b0;
            used_count <= used_count - 1'b1;
          end
        end
        ffca_pkg::S_T2: begin
          if (fprev == ffca_pkg::NIL) free_head <= ffca_pkg::NIL;
          boundary <= p_start;
          if (ffca_pkg::is_live(vld, cp)) begin
            vld[cp[ffca_pkg::SLOT_W-1:0]] <= 1'b0;
            used_count <= used_count - 1'b1;
          end
        end
        ffca_pkg::S_F3: if (e != fc && fprev == ffca_pkg::NIL) free_head <= fc;
        ffca_pkg::S_CLEAR: begin
          free_head <= ffca_pkg::NIL;
          boundary  <= first_length;
          if (first_length != '0) begin
            vld        <= ffca_pkg::vld_t'(1);
            used_count <= ffca_pkg::COUNT_W'(1);
          end else begin
            vld        <= '0;
            used_count <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // walk registers and result fields
  always_ff @(posedge clk) begin
    case (state)
      ffca_pkg::S_IDLE: begin
        if (req_valid) begin
          mode       <= req.op;
          len_r      <= req.length;
          off_r      <= req.offset;
          first_r    <= req.first_slot;
          has_r      <= req.has_first;
          tslot      <= {1'b0, req.first_slot};
          fc         <= req.has_first ? {1'b0, req.first_slot} : ffca_pkg::NIL;
          steps      <= '0;
          scan       <= '0;
          res_status <= ffca_pkg::ST_OK;
          res_slot   <= (req_ext && req.has_first) ? req.first_slot : '0;
          res_coff   <= '0;
          res_clen   <= '0;
          res_nslot  <= '0;
          res_hnext  <= 1'b0;
          if (req_bad && (req_ext || req.op == ffca_pkg::OP_FREE)) begin
            res_status <= ffca_pkg::ST_NOT_FOUND;
            res_slot   <= '0;
          end
        end
      end
      ffca_pkg::S_TAIL: begin
        if (tail_go) begin
          tslot <= rd_nx;
          steps <= steps_inc;
        end
      end
      ffca_pkg::S_A0: begin
        acur  <= head_live;
        aprev <= ffca_pkg::NIL;
        steps <= '0;
      end
      ffca_pkg::S_A1: begin
        if (a_fit) begin
          got      <= acur[ffca_pkg::SLOT_W-1:0];
          res_coff <= rd_start;
          if (a_exact) anx <= rd_nx;
          else if (ns_ok) anx <= ns;
          else begin
            res_status <= ffca_pkg::ST_FULL;
            res_slot   <= '0;
            res_coff   <= '0;
          end
        end else begin
          aprev <= acur;
          acur  <= rd_nx;
          steps <= steps_inc;
        end
      end
      ffca_pkg::S_CUTNIL: begin
        res_clen <= len_r;
        res_slot <= ext_chain ? first_r : got;
      end
      ffca_pkg::S_GROW: begin
        if (grow_ok) begin
          got      <= ns[ffca_pkg::SLOT_W-1:0];
          res_coff <= boundary;
          res_clen <= len_r;
          res_slot <= ext_chain ? first_r : ns[ffca_pkg::SLOT_W-1:0];
        end else begin
          res_status <= ffca_pkg::ST_FULL;
          res_slot   <= '0;
        end
      end
      ffca_pkg::S_C0: cp <= cfrom;
      ffca_pkg::S_C1: begin
        p_start <= rd_start;
        p_size  <= rd_size;
        cn      <= rd_nx;
        steps   <= '0;
      end
      ffca_pkg::S_C2: begin
        steps <= steps_inc;
        cn    <= c2_nxn;
        if (merge) p_size <= p_size + rd_size;
        else begin
          cp      <= cn;
          p_start <= rd_start;
          p_size  <= rd_size;
        end
      end
      ffca_pkg::S_T0: begin
        e     <= head_live;
        fprev <= ffca_pkg::NIL;
        s2    <= '0;
      end
      ffca_pkg::S_T1: begin
        if (t1_adv) begin
          fprev <= e;
          e     <= rd_nx;
          s2    <= s2 + 1'b1;
        end
      end
      ffca_pkg::S_F1: begin
        c_start <= rd_start;
        fnx     <= rd_nx;
        fprev   <= ffca_pkg::NIL;
        e       <= head_live;
        s2      <= '0;
      end
      ffca_pkg::S_F2: begin
        if (f2_adv) begin
          fprev <= e;
          e     <= rd_nx;
          s2    <= s2 + 1'b1;
        end
      end
      ffca_pkg::S_F3: begin
        if (!(e != fc && fprev != ffca_pkg::NIL)) begin
          fc    <= fnx;
          steps <= steps_inc;
        end
      end
      ffca_pkg::S_F4: begin
        fc    <= fnx;
        steps <= steps_inc;
      end
      ffca_pkg::S_FIND: begin
        if (find_hit) begin
          res_slot <= scan;
          res_coff <= rd_start;
          res_clen <= rd_size;
          if (rd_nx != ffca_pkg::NIL) begin
            res_nslot <= rd_nx[ffca_pkg::SLOT_W-1:0];
            res_hnext <= 1'b1;
          end
        end else if (find_last) res_status <= ffca_pkg::ST_NOT_FOUND;
        else scan <= scan + 1'b1;
      end
      ffca_pkg::S_DONE: begin
        if (out_free) begin
          rsp.status       <= res_status;
          rsp.slot         <= res_slot;
          rsp.chunk_offset <= res_coff;
          rsp.chunk_length <= res_clen;
          rsp.next_slot    <= res_nslot;
          rsp.has_next     <= res_hnext;
          rsp.empty_space  <= ffca_pkg::is_live(vld, free_head) ? rd_start : boundary;
          rsp.chunk_count  <= used_count;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    used_count == ffca_pkg::COUNT_W'($countones(vld)))
    else $error("chunk count out of step with valid bits");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ffca_pkg::S_DONE && out_free) |=> rsp_valid)
    else $error("finished result not presented");

  a_clear_small: assert property (@(posedge clk) disable iff (rst)
    (state == ffca_pkg::S_CLEAR) |=> (used_count <= ffca_pkg::COUNT_W'(1)))
    else $error("clear left more than one chunk");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != ffca_pkg::S_IDLE) |-> !req_ready)
    else $error("request taken while sequencer busy");
`endif

endmodule

`default_nettype wire
